@@ rtl/core/rpc_pkg.sv @@
// Shared types and constants for the radius point clusterer.
package rpc_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_W        = 16;
  localparam int RADIUS_W       = 10;
  localparam int LABEL_W        = 6;
  localparam int SIZE_W         = 7;

  localparam logic [RADIUS_W-1:0] LINK_RADIUS_RST = 10'd10;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [LABEL_W-1:0] point_index;
    logic [LABEL_W-1:0] cluster_label;
    logic [SIZE_W-1:0]  cluster_size;
    logic               dropped_points;
    logic               final_result;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic init;
    logic seed_skip;
    logic seed_take;
    logic pop;
    logic close;
    logic kfetch;
    logic klatch;
    logic scan;
    logic out_issue;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic flag_i;
    logic i_end;
    logic q_empty;
    logic j_last;
    logic pipe_busy;
    logic o_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

@@ rtl/core/radius_point_clusterer.sv @@
// Top level of the radius point clusterer.
//
// Input: a transaction is taken at a rising edge with start high and busy
// low; it carries one point (pos_x, pos_y) and end_of_set on the closing
// point. Points beyond MAX_POINTS are dropped and flagged. Busy stays low
// until the closing transaction, so each point is taken as it is offered.
// Configuration: cfg_valid with cfg_ready (always high) writes link_radius;
// write it only while busy is low.
// After the closing transaction busy rises and the set of n points is
// clustered. Each point popped from the walk queue takes a queue read, a
// coordinate fetch and latch, n pair tests issued one per cycle through the
// single read port of the coordinate stores, and a drain of the three-stage
// distance pipeline. Then the n results stream out on consecutive cycles,
// each for one cycle with out_valid high, final_result on the last; busy
// stays high after it through the output drain and the clearing state. The
// receiver cannot stall.
// Reset (rst_n low, synchronous) empties the set, clears the flags and
// restores link_radius to 10; no clearing pass is needed.
module radius_point_clusterer #(
  parameter int MAX_POINTS = rpc_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rpc_pkg::in_item_t            in_data,
  output logic                         out_valid,
  output rpc_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rpc_pkg::RADIUS_W-1:0] cfg_data
);
  import rpc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  rpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .end_of_set (in_data.end_of_set),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  rpc_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/rpc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/rpc_dp.sv @@
// Datapath: point stores, walk queue, distance pipeline, label and size stores.
module rpc_dp #(
  parameter int MAX_POINTS = rpc_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rpc_pkg::ctrl_cmd_t                cmd,
  output rpc_pkg::ctrl_sts_t                sts,
  input  rpc_pkg::in_item_t                 in_data,
  input  logic                              cfg_valid,
  input  logic [rpc_pkg::RADIUS_W-1:0]      cfg_data,
  output logic                              out_valid,
  output rpc_pkg::out_item_t                out_data
);
  import rpc_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [RADIUS_W-1:0]   link_radius_r;
  logic [2*RADIUS_W-1:0] r2_r;
  logic [CNT_W-1:0]      count_r;
  logic                  ovf_r;
  logic [MAX_POINTS-1:0] flags_r;
  logic [CNT_W-1:0]      i_r;
  logic [CNT_W-1:0]      head_r;
  logic [CNT_W-1:0]      tail_r;
  logic [CNT_W-1:0]      j_r;
  logic [CNT_W-1:0]      o_r;
  logic [COORD_W-1:0]    kx_r;
  logic [COORD_W-1:0]    ky_r;

  logic                  s1_v_r;
  logic [IDX_W-1:0]      s1_j_r;
  logic                  s2_v_r;
  logic [IDX_W-1:0]      s2_j_r;
  logic [COORD_W-1:0]    s2_adx_r;
  logic [COORD_W-1:0]    s2_ady_r;
  logic                  s3_v_r;
  logic [IDX_W-1:0]      s3_j_r;
  logic [2*COORD_W-1:0]  s3_sqx_r;
  logic [2*COORD_W-1:0]  s3_sqy_r;

  logic                  ov1_r;
  logic [IDX_W-1:0]      oidx1_r;
  logic                  olast1_r;
  logic                  ov2_r;
  logic [IDX_W-1:0]      oidx2_r;
  logic [IDX_W-1:0]      olab2_r;
  logic                  olast2_r;

  logic                  room;
  logic [IDX_W-1:0]      xy_raddr;
  logic [COORD_W-1:0]    x_rdata;
  logic [COORD_W-1:0]    y_rdata;
  logic [IDX_W-1:0]      q_rdata;
  logic [IDX_W-1:0]      lab_rdata;
  logic [CNT_W-1:0]      size_rdata;
  logic [COORD_W:0]      dx;
  logic [COORD_W:0]      dy;
  logic [2*COORD_W:0]    dist_sq;
  logic                  hit;
  logic                  push_we;
  logic [IDX_W-1:0]      lab_waddr;
  logic [IDX_W-1:0]      q_waddr;
  logic [IDX_W-1:0]      q_wdata;

  assign room     = count_r < CNT_W'(MAX_POINTS);
  assign xy_raddr = cmd.kfetch ? q_rdata : j_r[IDX_W-1:0];

  assign dx = {x_rdata[COORD_W-1], x_rdata} - {kx_r[COORD_W-1], kx_r};
  assign dy = {y_rdata[COORD_W-1], y_rdata} - {ky_r[COORD_W-1], ky_r};

  assign dist_sq = {1'b0, s3_sqx_r} + {1'b0, s3_sqy_r};
  assign hit     = s3_v_r && !flags_r[s3_j_r] &&
                   (dist_sq < (2*COORD_W+1)'(r2_r));

  assign push_we   = cmd.seed_take || hit;
  assign lab_waddr = cmd.seed_take ? i_r[IDX_W-1:0] : s3_j_r;
  assign q_waddr   = cmd.seed_take ? '0 : tail_r[IDX_W-1:0];
  assign q_wdata   = cmd.seed_take ? i_r[IDX_W-1:0] : s3_j_r;

  rpc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk   (clk),
    .we    (cmd.load && room),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_data.pos_x),
    .raddr (xy_raddr),
    .rdata (x_rdata)
  );

  rpc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk   (clk),
    .we    (cmd.load && room),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_data.pos_y),
    .raddr (xy_raddr),
    .rdata (y_rdata)
  );

  rpc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_queue_ram (
    .clk   (clk),
    .we    (push_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r[IDX_W-1:0]),
    .rdata (q_rdata)
  );

  rpc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_label_ram (
    .clk   (clk),
    .we    (push_we),
    .waddr (lab_waddr),
    .wdata (i_r[IDX_W-1:0]),
    .raddr (o_r[IDX_W-1:0]),
    .rdata (lab_rdata)
  );

  rpc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_POINTS)) u_size_ram (
    .clk   (clk),
    .we    (cmd.close),
    .waddr (i_r[IDX_W-1:0]),
    .wdata (tail_r),
    .raddr (lab_rdata),
    .rdata (size_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_radius_r <= LINK_RADIUS_RST;
      count_r       <= '0;
      ovf_r         <= 1'b0;
      flags_r       <= '0;
      i_r           <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      j_r           <= '0;
      o_r           <= '0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      s3_v_r        <= 1'b0;
      ov1_r         <= 1'b0;
      ov2_r         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        link_radius_r <= cfg_data;
      end
      if (cmd.load) begin
        if (room) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.init) begin
        i_r <= '0;
        o_r <= '0;
      end
      if (cmd.seed_skip || cmd.close) begin
        i_r <= i_r + CNT_W'(1);
      end
      if (cmd.seed_take) begin
        flags_r[i_r[IDX_W-1:0]] <= 1'b1;
        head_r                  <= '0;
        tail_r                  <= CNT_W'(1);
      end
      if (cmd.pop) begin
        head_r <= head_r + CNT_W'(1);
      end
      if (cmd.klatch) begin
        j_r <= '0;
      end
      if (cmd.scan) begin
        j_r <= j_r + CNT_W'(1);
      end
      if (hit) begin
        flags_r[s3_j_r] <= 1'b1;
        tail_r          <= tail_r + CNT_W'(1);
      end
      if (cmd.out_issue) begin
        o_r <= o_r + CNT_W'(1);
      end
      if (cmd.clear) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        flags_r <= '0;
      end
      s1_v_r <= cmd.scan;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      ov1_r  <= cmd.out_issue;
      ov2_r  <= ov1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      r2_r <= {{RADIUS_W{1'b0}}, link_radius_r} * {{RADIUS_W{1'b0}}, link_radius_r};
    end
    if (cmd.klatch) begin
      kx_r <= x_rdata;
      ky_r <= y_rdata;
    end
    s1_j_r   <= j_r[IDX_W-1:0];
    s2_j_r   <= s1_j_r;
    s2_adx_r <= dx[COORD_W] ? COORD_W'(~dx + 1'b1) : dx[COORD_W-1:0];
    s2_ady_r <= dy[COORD_W] ? COORD_W'(~dy + 1'b1) : dy[COORD_W-1:0];
    s3_j_r   <= s2_j_r;
    s3_sqx_r <= {{COORD_W{1'b0}}, s2_adx_r} * {{COORD_W{1'b0}}, s2_adx_r};
    s3_sqy_r <= {{COORD_W{1'b0}}, s2_ady_r} * {{COORD_W{1'b0}}, s2_ady_r};
    oidx1_r  <= o_r[IDX_W-1:0];
    olast1_r <= sts.o_last;
    oidx2_r  <= oidx1_r;
    olab2_r  <= lab_rdata;
    olast2_r <= olast1_r;
  end

  always_comb begin
    sts.flag_i    = flags_r[i_r[IDX_W-1:0]];
    sts.i_end     = i_r == count_r;
    sts.q_empty   = head_r == tail_r;
    sts.j_last    = j_r + CNT_W'(1) == count_r;
    sts.pipe_busy = s1_v_r || s2_v_r || s3_v_r;
    sts.o_last    = o_r + CNT_W'(1) == count_r;
    sts.out_busy  = ov1_r || ov2_r;
  end

  assign out_valid               = ov2_r;
  assign out_data.point_index    = LABEL_W'(oidx2_r);
  assign out_data.cluster_label  = LABEL_W'(olab2_r);
  assign out_data.cluster_size   = SIZE_W'(size_rdata);
  assign out_data.dropped_points = ovf_r;
  assign out_data.final_result   = olast2_r;

endmodule

@@ rtl/core/rpc_ctrl.sv @@
// Controller state machine sequencing load, cluster walk and result output.
module rpc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               end_of_set,
  input  rpc_pkg::ctrl_sts_t sts,
  output rpc_pkg::ctrl_cmd_t cmd,
  output logic               busy
);
  import rpc_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_INIT   = 11'b000_0000_0010,
    ST_SEED   = 11'b000_0000_0100,
    ST_POP    = 11'b000_0000_1000,
    ST_FETCH  = 11'b000_0001_0000,
    ST_KLATCH = 11'b000_0010_0000,
    ST_SCAN   = 11'b000_0100_0000,
    ST_DRAIN  = 11'b000_1000_0000,
    ST_OUT    = 11'b001_0000_0000,
    ST_ODRAIN = 11'b010_0000_0000,
    ST_CLEAR  = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (end_of_set) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_SEED;
      end
      ST_SEED: begin
        if (sts.i_end) begin
          state_nxt = ST_OUT;
        end else if (sts.flag_i) begin
          cmd.seed_skip = 1'b1;
        end else begin
          cmd.seed_take = 1'b1;
          state_nxt     = ST_POP;
        end
      end
      ST_POP: begin
        if (sts.q_empty) begin
          cmd.close = 1'b1;
          state_nxt = ST_SEED;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.kfetch = 1'b1;
        state_nxt  = ST_KLATCH;
      end
      ST_KLATCH: begin
        cmd.klatch = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.j_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_POP;
        end
      end
      ST_OUT: begin
        cmd.out_issue = 1'b1;
        if (sts.o_last) begin
          state_nxt = ST_ODRAIN;
        end
      end
      ST_ODRAIN: begin
        if (!sts.out_busy) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;

endmodule

@@ rtl/core/rpc_checker.sv @@
// Port-level checker for the radius point clusterer, with its bind.
module rpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input rpc_pkg::out_item_t out_data
);
  import rpc_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("busy or result after reset");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result while idle");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.final_result) |=> !out_valid)
    else $error("result after final result");

  a_stream_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.final_result) |=>
      (out_valid && out_data.point_index ==
       LABEL_W'($past(out_data.point_index) + 1'b1)))
    else $error("result stream broken or out of order");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_data.point_index == '0))
    else $error("set does not start at point zero");

endmodule

bind radius_point_clusterer rpc_checker u_rpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
